// ===== hw/rtl/cubic_bezier_tessellator_macros.svh =====
// Assertion macros used by the tessellator top level.
`ifndef CUBIC_BEZIER_TESSELLATOR_MACROS_SVH
`define CUBIC_BEZIER_TESSELLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BZT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BZT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bzt_pkg.sv =====
// Types and constants of the cubic Bezier tessellator.
`timescale 1ns / 1ps
package bzt_pkg;
	localparam int COORD_W = 24;
	localparam int HALF_W  = COORD_W / 2;
	localparam int RES_W   = 6;
	localparam int IDX_W   = 6;
	localparam int SEG_W   = 25;
	localparam int TOT_W   = 31;
	localparam int COEF_W  = 28;
	localparam int MUL_A_W = 43;
	localparam int MUL_B_W = 13;
	localparam int PROD_W  = 56;
	localparam int DIVN_W  = 48;
	localparam int DIVD_W  = 3 * IDX_W + 1;
	localparam int QUOT_W  = 27;
	localparam int BIAS_SH = 26;
	localparam int SQ_W    = 50;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] ctrl1_x;
		logic signed [COORD_W-1:0] ctrl1_y;
		logic signed [COORD_W-1:0] ctrl2_x;
		logic signed [COORD_W-1:0] ctrl2_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [RES_W-1:0]          resolution;
	} curve_t;

	typedef struct packed {
		logic [IDX_W-1:0]          vertex_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [SEG_W-1:0]          segment_length;
		logic [TOT_W-1:0]          total_length;
		logic                      last_vertex;
	} vertex_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETUP,
		ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
		ST_DIV, ST_DIVW,
		ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6,
		ST_SQRT, ST_SQRTW, ST_EMIT
	} state_t;
endpackage

// ===== hw/rtl/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator top level: sequencer, coefficient registers, output register.
//
// Usage: one curve transfers on the curve channel (four points, signed Q16.8, and a
// resolution). The block emits resolution+2 vertices on the vertex channel, in order,
// each with its point, the rounded distance from the previous vertex, the saturating
// running length and a last flag. Resolutions above MAX_VERTICES-2 are clamped.
// curve_stall is high from the transfer of a curve until its last vertex is loaded
// into the output register; the next curve may transfer while that vertex still waits.
// The first vertex, the start point, is loaded after a setup step. Every further vertex
// takes per axis 7 steps on the shared multiplier plus the bit-serial divider, then 6
// multiplier steps and the square root unit. A stalled receiver holds the output
// register and the sequencer waits in its emit step; nothing is dropped. Reset clears
// the sequencer and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps
`include "cubic_bezier_tessellator_macros.svh"
module cubic_bezier_tessellator #(
	parameter int MAX_VERTICES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             curve_valid,
	output logic             curve_stall,
	input  bzt_pkg::curve_t  curve,
	output logic             vertex_valid,
	input  logic             vertex_stall,
	output bzt_pkg::vertex_t vertex
);
	import bzt_pkg::*;

	localparam int RES_MAX = MAX_VERTICES - 2;

	state_t state_q, state_d;

	logic                      axis_q;
	logic [IDX_W-1:0]          idx_q, d_q;
	logic [2*IDX_W-1:0]        d2_q;
	logic [3*IDX_W-1:0]        d3_q;
	logic signed [COEF_W-1:0]  ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
	logic signed [COORD_W-1:0] x0_q, y0_q, nx_q, ny_q, px_q, py_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic [SEG_W-1:0]          seg_q;
	logic [TOT_W-1:0]          total_q;
	vertex_t                   vertex_q;
	logic                      vertex_valid_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      div_start, div_busy;
	logic [DIVN_W-1:0]         div_num;
	logic [QUOT_W-1:0]         quot;
	logic                      sqrt_start, sqrt_busy;
	logic [SEG_W-1:0]          root;
	logic                      load_out;

	logic [RES_W-1:0]          res_c;
	logic [IDX_W-1:0]          d_in;
	logic signed [COEF_W-1:0]  cx_in, bx_in, ax_in, cy_in, by_in, ay_in;
	logic signed [COEF_W-1:0]  a_sel, b_sel, c_sel;
	logic signed [COORD_W-1:0] p0_sel;
	logic signed [QUOT_W:0]    coord_full;
	logic signed [COORD_W:0]   dx, dy;
	logic [COORD_W-1:0]        ux, uy;
	logic [TOT_W:0]            tsum;

	// clamp resolution and form power-basis coefficients
	assign res_c = ((RES_W+1)'(curve.resolution) > (RES_W+1)'(RES_MAX)) ?
		RES_W'(RES_MAX) : curve.resolution;
	assign d_in  = IDX_W'(res_c) + 1'b1;

	assign cx_in = COEF_W'(3) * (COEF_W'(curve.ctrl1_x) - COEF_W'(curve.start_x));
	assign bx_in = COEF_W'(3) * (COEF_W'(curve.ctrl2_x) - COEF_W'(curve.ctrl1_x)) - cx_in;
	assign ax_in = COEF_W'(curve.end_x) - COEF_W'(curve.start_x) - cx_in - bx_in;
	assign cy_in = COEF_W'(3) * (COEF_W'(curve.ctrl1_y) - COEF_W'(curve.start_y));
	assign by_in = COEF_W'(3) * (COEF_W'(curve.ctrl2_y) - COEF_W'(curve.ctrl1_y)) - cy_in;
	assign ay_in = COEF_W'(curve.end_y) - COEF_W'(curve.start_y) - cy_in - by_in;

	assign a_sel  = axis_q ? ay_q : ax_q;
	assign b_sel  = axis_q ? by_q : bx_q;
	assign c_sel  = axis_q ? cy_q : cx_q;
	assign p0_sel = axis_q ? y0_q : x0_q;

	// biased numerator keeps the dividend positive: 2*num + d3*(2^26 + 1)
	assign div_num = DIVN_W'({prod_q, 1'b0}) + (DIVN_W'(d3_q) << BIAS_SH) + DIVN_W'(d3_q);
	assign coord_full = (QUOT_W+1)'(p0_sel) + $signed({1'b0, quot})
		- (QUOT_W+1)'(1 << (BIAS_SH - 1));

	assign dx = (COORD_W+1)'(nx_q) - (COORD_W+1)'(px_q);
	assign dy = (COORD_W+1)'(ny_q) - (COORD_W+1)'(py_q);
	assign ux = COORD_W'(dx[COORD_W] ? -dx : dx);
	assign uy = COORD_W'(dy[COORD_W] ? -dy : dy);

	assign tsum = (TOT_W+1)'(total_q) + (TOT_W+1)'(root);

	bzt_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	bzt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (DIVD_W'({d3_q, 1'b0})),
		.busy   (div_busy),
		.quot   (quot)
	);

	bzt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q[SQ_W-1:0]),
		.busy     (sqrt_busy),
		.root     (root)
	);

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (curve_valid) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_EMIT;
			ST_M1: begin
				mul_a   = MUL_A_W'(a_sel);
				mul_b   = MUL_B_W'(idx_q);
				state_d = ST_M2;
			end
			ST_M2: begin
				mul_a   = MUL_A_W'(b_sel);
				mul_b   = MUL_B_W'(d_q);
				state_d = ST_M3;
			end
			ST_M3: state_d = ST_M4;
			ST_M4: begin
				mul_a   = acc_q[MUL_A_W-1:0];
				mul_b   = MUL_B_W'(idx_q);
				state_d = ST_M5;
			end
			ST_M5: begin
				mul_a   = MUL_A_W'(c_sel);
				mul_b   = MUL_B_W'(d2_q);
				state_d = ST_M6;
			end
			ST_M6: state_d = ST_M7;
			ST_M7: begin
				mul_a   = acc_q[MUL_A_W-1:0];
				mul_b   = MUL_B_W'(idx_q);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: begin
				if (!div_busy) state_d = axis_q ? ST_Q1 : ST_M1;
			end
			ST_Q1: begin
				mul_a   = MUL_A_W'(ux);
				mul_b   = MUL_B_W'(ux[HALF_W-1:0]);
				state_d = ST_Q2;
			end
			ST_Q2: begin
				mul_a   = MUL_A_W'(ux);
				mul_b   = MUL_B_W'(ux[COORD_W-1:HALF_W]);
				state_d = ST_Q3;
			end
			ST_Q3: state_d = ST_Q4;
			ST_Q4: begin
				mul_a   = MUL_A_W'(uy);
				mul_b   = MUL_B_W'(uy[HALF_W-1:0]);
				state_d = ST_Q5;
			end
			ST_Q5: begin
				mul_a   = MUL_A_W'(uy);
				mul_b   = MUL_B_W'(uy[COORD_W-1:HALF_W]);
				state_d = ST_Q6;
			end
			ST_Q6: state_d = ST_SQRT;
			ST_SQRT: begin
				sqrt_start = 1'b1;
				state_d    = ST_SQRTW;
			end
			ST_SQRTW: begin
				if (!sqrt_busy) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!vertex_valid_q || !vertex_stall) begin
					load_out = 1'b1;
					state_d  = (idx_q == d_q) ? ST_IDLE : ST_M1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				vertex_valid_q <= 1'b1;
			end else if (!vertex_stall) begin
				vertex_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			vertex_q <= '{vertex_index: idx_q, point_x: nx_q, point_y: ny_q,
				segment_length: seg_q, total_length: total_q,
				last_vertex: (idx_q == d_q)};
		end
		case (state_q) inside
			ST_IDLE: begin
				if (curve_valid) begin
					x0_q <= curve.start_x;
					y0_q <= curve.start_y;
					ax_q <= ax_in;
					bx_q <= bx_in;
					cx_q <= cx_in;
					ay_q <= ay_in;
					by_q <= by_in;
					cy_q <= cy_in;
					d_q  <= d_in;
					d2_q <= (2*IDX_W)'(d_in) * (2*IDX_W)'(d_in);
				end
			end
			ST_SETUP: begin
				d3_q    <= (3*IDX_W)'(d2_q) * (3*IDX_W)'(d_q);
				nx_q    <= x0_q;
				ny_q    <= y0_q;
				seg_q   <= '0;
				total_q <= '0;
				idx_q   <= '0;
				axis_q  <= 1'b0;
			end
			ST_M2, ST_M5, ST_Q2: acc_q <= prod_q;
			ST_M3, ST_M6, ST_Q5: acc_q <= acc_q + prod_q;
			ST_Q3, ST_Q6:        acc_q <= acc_q + (prod_q <<< HALF_W);
			ST_DIVW: begin
				if (!div_busy) begin
					if (axis_q) ny_q <= COORD_W'(coord_full);
					else        nx_q <= COORD_W'(coord_full);
					axis_q <= ~axis_q;
				end
			end
			ST_SQRTW: begin
				if (!sqrt_busy) begin
					seg_q   <= root;
					total_q <= tsum[TOT_W] ? {TOT_W{1'b1}} : tsum[TOT_W-1:0];
				end
			end
			ST_EMIT: begin
				if (load_out) begin
					px_q  <= nx_q;
					py_q  <= ny_q;
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign curve_stall  = (state_q != ST_IDLE);
	assign vertex_valid = vertex_valid_q;
	assign vertex       = vertex_q;

	`BZT_ASSERT_NEXT(a_accept_starts, curve_valid && !curve_stall, state_q == ST_SETUP, "curve transfer did not start the sequencer")
	`BZT_ASSERT_IMP(a_first_zero, vertex_valid && vertex.vertex_index == '0, vertex.segment_length == '0 && vertex.total_length == '0, "first vertex carries nonzero length")
	`BZT_ASSERT_IMP(a_total_covers_seg, vertex_valid, vertex.total_length >= TOT_W'(vertex.segment_length), "running length below segment length")
endmodule

// ===== hw/rtl/bzt_mul.sv =====
// Shared registered multiplier: signed operand times unsigned operand.
`timescale 1ns / 1ps
module bzt_mul (
	input  logic                               clk,
	input  logic signed [bzt_pkg::MUL_A_W-1:0] a,
	input  logic [bzt_pkg::MUL_B_W-1:0]        b,
	output logic signed [bzt_pkg::PROD_W-1:0]  prod_q
);
	import bzt_pkg::*;

	logic signed [MUL_A_W+MUL_B_W:0] full;

	assign full = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		prod_q <= full[PROD_W-1:0];
	end
endmodule

// ===== hw/rtl/bzt_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bzt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bzt_pkg::DIVN_W-1:0]  num,
	input  logic [bzt_pkg::DIVD_W-1:0]  den,
	output logic                        busy,
	output logic [bzt_pkg::QUOT_W-1:0]  quot
);
	import bzt_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic [DIVN_W-1:0] rem_q;
	logic [DIVN_W-1:0] dv_q;
	logic [QUOT_W-1:0] q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              fits;

	assign fits = (rem_q >= dv_q);
	assign busy = busy_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dv_q  <= DIVN_W'(den) << (QUOT_W - 1);
			q_q   <= '0;
			cnt_q <= CNT_W'(QUOT_W - 1);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dv_q;
			end
			q_q   <= {q_q[QUOT_W-2:0], fits};
			dv_q  <= dv_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== hw/rtl/bzt_sqrt.sv =====
// Digit-by-digit square root, rounded to nearest.
`timescale 1ns / 1ps
module bzt_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bzt_pkg::SQ_W-1:0]   radicand,
	output logic                       busy,
	output logic [bzt_pkg::SEG_W-1:0]  root
);
	import bzt_pkg::*;

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            busy_q;

	assign trial = r_q + bit_q;
	assign busy  = busy_q;
	// remainder is s - r*r, so round up when it exceeds r
	assign root  = SEG_W'(r_q + SQ_W'(rem_q > r_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				r_q   <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
